/* hdl/irtu_pkg.sv */
`timescale 1ns / 1ps

package irtu_pkg;

    // fixed point scale of triad and rotation entries
    localparam int FRAC_BITS = 30;

    localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] RND_W   = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] RND_A   = 64'sd1 <<< (FRAC_BITS - 3);
    localparam logic signed [63:0] RND_R   = 64'sd1 <<< (FRAC_BITS - 4);
    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

    // cordic angles are q.30 and carry 36 bits
    localparam int CW = 36;
    localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;

    localparam int CORDIC_STEPS = 28;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_W        = CW + FRAC_BITS;
    localparam int DIV_STEPS    = DIV_W;
    localparam int TRIAD_N      = 9;

    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_RESTART = 2'd2,
        OP_LOAD    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_WRAP,
        ST_FOLD,
        ST_CORDIC,
        ST_SC,
        ST_DIV,
        ST_H,
        ST_W,
        ST_A,
        ST_WSQ,
        ST_RGEN,
        ST_MM,
        ST_OUT
    } state_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] v;
        unique case (i)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    // row-major element number
    function automatic logic [3:0] elem_idx(input logic [1:0] r, input logic [1:0] c);
        return 4'(4'(r) * 4'd3 + 4'(c));
    endfunction

    // clamp to the closed range of one rotation entry
    function automatic logic signed [31:0] clamp_one(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q) begin
            r = 32'(ONE_Q);
        end else if (v < -ONE_Q) begin
            r = 32'(-ONE_Q);
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

/* hdl/incremental_rotation_triad_update.sv */
`timescale 1ns / 1ps

// Incremental rotation triad update: holds a committed and a trial 3x3 rotation triad
// (row-major, signed q1.30). Each input beat carries the operation in s_tuser: a trial update
// averages the two node spin increments (q3.28) into psi and sets trial = R(psi) * committed
// with the Rodrigues rotation R, commit copies trial into committed, restart copies committed
// into trial, and load writes one element of both triads (indices 9..15 write nothing). Every
// beat returns one output beat with the nine trial elements after the operation. Commit,
// restart and load go from accept straight to the output state. A trial update runs
// a radix-4 square root of 32 steps, 28 cordic steps, a restoring divide of 66
// steps, and 48 products through one shared 32x32 multiplier, each product taking an issue
// and an accumulate phase; a zero spin ends after the squaring pass. s_tready is high only
// while the sequencer is idle; the output register lets the next beat be accepted while
// the last result still waits on m_tready. Both triads reset to the identity.
module incremental_rotation_triad_update
    import irtu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // node_a_spin_x, node_a_spin_y, node_a_spin_z, node_b_spin_x, node_b_spin_y,
    // node_b_spin_z, load_index, load_value, zero pad
    input  logic [231:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // trial_r11, trial_r12, trial_r13, trial_r21, trial_r22, trial_r23,
    // trial_r31, trial_r32, trial_r33
    output logic [287:0] m_tdata
);

    // sequencer
    state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic       ph_reg, ph_next;

    // triads
    logic signed [31:0] com_reg [TRIAD_N];
    logic signed [31:0] com_next [TRIAD_N];
    logic signed [31:0] tri_reg [TRIAD_N];
    logic signed [31:0] tri_next [TRIAD_N];

    // datapath
    logic signed [31:0] psi_reg [3];
    logic signed [31:0] psi_next [3];
    logic [63:0] ss_reg, ss_next;
    logic [63:0] sq_rem_reg, sq_rem_next, sq_res_reg, sq_res_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic flip_reg, flip_next;
    logic [33:0] div_rem_reg, div_rem_next;
    logic [DIV_W-1:0] div_nq_reg, div_nq_next;
    logic s_neg_reg, s_neg_next;
    logic signed [31:0] c_reg, c_next, h_reg, h_next;
    logic signed [31:0] w_reg [3];
    logic signed [31:0] w_next [3];
    logic signed [33:0] a_reg [3];
    logic signed [33:0] a_next [3];
    logic signed [63:0] wsq_reg, wsq_next;
    logic signed [31:0] r_reg [TRIAD_N];
    logic signed [31:0] r_next [TRIAD_N];
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg, prod_next;

    // output register
    logic         out_valid_reg, out_valid_next;
    logic [287:0] out_data_reg, out_data_next;

    // shared multiplier operands
    logic signed [31:0] mul_a, mul_b;

    // input beat fields
    op_t                in_op;
    logic signed [31:0] in_spin [6];
    logic [3:0]         in_load_index;
    logic signed [31:0] in_load_value;
    logic               s_acc;
    logic signed [CW-1:0] ang_w;

    assign in_op         = op_t'(s_tuser);
    assign in_load_index = s_tdata[195:192];
    assign in_load_value = s_tdata[227:196];
    always_comb begin
        for (int n = 0; n < 6; n++) begin
            in_spin[n] = s_tdata[32*n +: 32];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // half angle 2*floor(sqrt(ss)) in q.30
    assign ang_w = {3'b000, sq_res_reg[31:0], 1'b0};

    assign prod_next = mul_a * mul_b;

    always_comb begin
        logic signed [32:0]   sum33;
        logic [63:0]          ss_sum;
        logic [63:0]          sq_bit;
        logic [63:0]          sq_try;
        logic signed [CW-1:0] dx, dy, at, xs;
        logic [CW-1:0]        s_mag;
        logic [34:0]          dv_try, dv_d;
        logic signed [31:0]   hm;
        logic signed [63:0]   rr, dsub, dadd, sk, acc_sum, rd;
        logic [3:0]           e;

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        ph_next      = ph_reg;
        com_next     = com_reg;
        tri_next     = tri_reg;
        psi_next     = psi_reg;
        ss_next      = ss_reg;
        sq_rem_next  = sq_rem_reg;
        sq_res_next  = sq_res_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        flip_next    = flip_reg;
        div_rem_next = div_rem_reg;
        div_nq_next  = div_nq_reg;
        s_neg_next   = s_neg_reg;
        c_next       = c_reg;
        h_next       = h_reg;
        w_next       = w_reg;
        a_next       = a_reg;
        wsq_next     = wsq_reg;
        r_next       = r_reg;
        acc_next     = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        mul_a = '0;
        mul_b = '0;
        sum33 = '0;
        ss_sum = '0;
        sq_bit = '0;
        sq_try = '0;
        dx = '0;
        dy = '0;
        at = '0;
        xs = '0;
        s_mag = '0;
        dv_try = '0;
        dv_d = '0;
        hm = '0;
        rr = '0;
        dsub = '0;
        dadd = '0;
        sk = '0;
        acc_sum = '0;
        rd = '0;
        e = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (in_op)
                        OP_UPDATE: begin
                            for (int n = 0; n < 3; n++) begin
                                sum33 = 33'(in_spin[n]) + 33'(in_spin[n+3]);
                                psi_next[n] = sum33[32:1];
                            end
                            ss_next    = '0;
                            k_next     = '0;
                            ph_next    = 1'b0;
                            state_next = ST_SQ;
                        end
                        OP_COMMIT: begin
                            com_next   = tri_reg;
                            state_next = ST_OUT;
                        end
                        OP_RESTART: begin
                            tri_next   = com_reg;
                            state_next = ST_OUT;
                        end
                        OP_LOAD: begin
                            if (in_load_index < 4'(TRIAD_N)) begin
                                com_next[in_load_index] = in_load_value;
                                tri_next[in_load_index] = in_load_value;
                            end
                            state_next = ST_OUT;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end

            // squared norm of psi
            ST_SQ: begin
                mul_a = psi_reg[k_reg];
                mul_b = psi_reg[k_reg];
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    ss_sum  = ss_reg + $unsigned(prod_reg);
                    ss_next = ss_sum;
                    if (k_reg == 2'd2) begin
                        if (ss_sum == 64'd0) begin
                            tri_next   = com_reg;
                            state_next = ST_OUT;
                        end else begin
                            sq_rem_next = ss_sum;
                            sq_res_next = '0;
                            cnt_next    = '0;
                            state_next  = ST_SQRT;
                        end
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            // digit-by-digit integer square root
            ST_SQRT: begin
                sq_bit = 64'd1 << (6'd62 - {cnt_reg[4:0], 1'b0});
                sq_try = sq_res_reg + sq_bit;
                if (sq_rem_reg >= sq_try) begin
                    sq_rem_next = sq_rem_reg - sq_try;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit;
                end else begin
                    sq_res_next = sq_res_reg >> 1;
                end
                if (cnt_reg == 7'(SQRT_STEPS - 1)) begin
                    state_next = ST_WRAP;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            ST_WRAP: begin
                cz_next    = (ang_w > PI_Q30) ? ang_w - TWO_PI_Q30 : ang_w;
                state_next = ST_FOLD;
            end

            // mirror into [-pi/2, pi/2], cosine flips sign
            ST_FOLD: begin
                if (cz_reg > HALF_PI_Q30) begin
                    cz_next   = PI_Q30 - cz_reg;
                    flip_next = 1'b1;
                end else if (cz_reg < -HALF_PI_Q30) begin
                    cz_next   = -PI_Q30 - cz_reg;
                    flip_next = 1'b1;
                end else begin
                    flip_next = 1'b0;
                end
                cx_next    = CORDIC_GAIN;
                cy_next    = '0;
                cnt_next   = '0;
                state_next = ST_CORDIC;
            end

            ST_CORDIC: begin
                dx = cy_reg >>> cnt_reg[4:0];
                dy = cx_reg >>> cnt_reg[4:0];
                at = atan_q30(cnt_reg[4:0]);
                if (!cz_reg[CW-1]) begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - at;
                end else begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + at;
                end
                if (cnt_reg == 7'(CORDIC_STEPS - 1)) begin
                    state_next = ST_SC;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            // latch sine and cosine, set up sin/angle divide
            ST_SC: begin
                xs           = flip_reg ? -cx_reg : cx_reg;
                c_next       = clamp_one(64'(xs));
                s_neg_next   = cy_reg[CW-1];
                s_mag        = cy_reg[CW-1] ? CW'(-cy_reg) : CW'(cy_reg);
                div_nq_next  = {s_mag, FRAC_BITS'(0)};
                div_rem_next = '0;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end

            // restoring divide, one quotient bit per cycle
            ST_DIV: begin
                dv_try = {div_rem_reg, div_nq_reg[DIV_W-1]};
                dv_d   = {2'b00, sq_res_reg[31:0], 1'b0};
                if (dv_try >= dv_d) begin
                    div_rem_next = 34'(dv_try - dv_d);
                    div_nq_next  = {div_nq_reg[DIV_W-2:0], 1'b1};
                end else begin
                    div_rem_next = dv_try[33:0];
                    div_nq_next  = {div_nq_reg[DIV_W-2:0], 1'b0};
                end
                if (cnt_reg == 7'(DIV_STEPS - 1)) begin
                    state_next = ST_H;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            ST_H: begin
                hm = (div_nq_reg > DIV_W'(ONE_Q)) ? 32'(ONE_Q) : $signed(div_nq_reg[31:0]);
                h_next     = s_neg_reg ? -hm : hm;
                k_next     = '0;
                ph_next    = 1'b0;
                state_next = ST_W;
            end

            ST_W: begin
                mul_a = h_reg;
                mul_b = psi_reg[k_reg];
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    w_next[k_reg] = clamp_one((prod_reg + RND_W) >>> FRAC_BITS);
                    if (k_reg == 2'd2) begin
                        k_next     = '0;
                        state_next = ST_A;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            // axial term w * cos
            ST_A: begin
                mul_a = w_reg[k_reg];
                mul_b = c_reg;
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    a_next[k_reg] = 34'((prod_reg + RND_A) >>> (FRAC_BITS - 2));
                    if (k_reg == 2'd2) begin
                        k_next     = '0;
                        wsq_next   = '0;
                        state_next = ST_WSQ;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            ST_WSQ: begin
                mul_a = w_reg[k_reg];
                mul_b = w_reg[k_reg];
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    wsq_next = wsq_reg + prod_reg;
                    if (k_reg == 2'd2) begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_RGEN;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            // rotation entries: identity + skew(A) + w w^T - |w|^2 I
            ST_RGEN: begin
                mul_a = w_reg[i_reg];
                mul_b = w_reg[j_reg];
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    e    = elem_idx(i_reg, j_reg);
                    dsub = (i_reg == j_reg) ? wsq_reg : 64'sd0;
                    dadd = (i_reg == j_reg) ? ONE_Q : 64'sd0;
                    unique case (e)
                        4'd1:    sk = -64'(a_reg[2]);
                        4'd2:    sk = 64'(a_reg[1]);
                        4'd3:    sk = 64'(a_reg[2]);
                        4'd5:    sk = -64'(a_reg[0]);
                        4'd6:    sk = -64'(a_reg[1]);
                        4'd7:    sk = 64'(a_reg[0]);
                        default: sk = 64'sd0;
                    endcase
                    rr = ((prod_reg - dsub) + RND_R) >>> (FRAC_BITS - 3);
                    r_next[e] = clamp_one(rr + dadd + sk);
                    if (j_reg == 2'd2) begin
                        j_next = '0;
                        if (i_reg == 2'd2) begin
                            i_next     = '0;
                            k_next     = '0;
                            acc_next   = '0;
                            state_next = ST_MM;
                        end else begin
                            i_next = i_reg + 2'd1;
                        end
                    end else begin
                        j_next = j_reg + 2'd1;
                    end
                end
            end

            // trial = R * committed, one product per issue
            ST_MM: begin
                mul_a = r_reg[elem_idx(i_reg, k_reg)];
                mul_b = com_reg[elem_idx(k_reg, j_reg)];
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    acc_sum = acc_reg + prod_reg;
                    if (k_reg == 2'd2) begin
                        rd = (acc_sum + RND_W) >>> FRAC_BITS;
                        if (rd > I32_MAX) begin
                            tri_next[elem_idx(i_reg, j_reg)] = 32'(I32_MAX);
                        end else if (rd < I32_MIN) begin
                            tri_next[elem_idx(i_reg, j_reg)] = 32'(I32_MIN);
                        end else begin
                            tri_next[elem_idx(i_reg, j_reg)] = 32'(rd);
                        end
                        acc_next = '0;
                        k_next   = '0;
                        if (j_reg == 2'd2) begin
                            j_next = '0;
                            if (i_reg == 2'd2) begin
                                state_next = ST_OUT;
                            end else begin
                                i_next = i_reg + 2'd1;
                            end
                        end else begin
                            j_next = j_reg + 2'd1;
                        end
                    end else begin
                        acc_next = acc_sum;
                        k_next   = k_reg + 2'd1;
                    end
                end
            end

            // hand the trial triad to the output register once it is free
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    for (int n = 0; n < TRIAD_N; n++) begin
                        out_data_next[32*n +: 32] = tri_reg[n];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control state and triads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            ph_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < TRIAD_N; n++) begin
                com_reg[n] <= (n % 4 == 0) ? 32'(ONE_Q) : 32'sd0;
                tri_reg[n] <= (n % 4 == 0) ? 32'(ONE_Q) : 32'sd0;
            end
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
            com_reg       <= com_next;
            tri_reg       <= tri_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        psi_reg      <= psi_next;
        ss_reg       <= ss_next;
        sq_rem_reg   <= sq_rem_next;
        sq_res_reg   <= sq_res_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        flip_reg     <= flip_next;
        div_rem_reg  <= div_rem_next;
        div_nq_reg   <= div_nq_next;
        s_neg_reg    <= s_neg_next;
        c_reg        <= c_next;
        h_reg        <= h_next;
        w_reg        <= w_next;
        a_reg        <= a_next;
        wsq_reg      <= wsq_next;
        r_reg        <= r_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // copy and load operations go straight to the output state
    a_short_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_op != OP_UPDATE) |=> (state_reg == ST_OUT))
        else $error("copy or load did not go straight to output");

    // nonzero spin always gives a nonzero root
    a_root_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRAP) |-> (sq_res_reg != 64'd0))
        else $error("square root zero for nonzero spin");

    // the first rotation entry stays within [-1, 1] during the product
    a_r_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MM) |-> (64'(r_reg[0]) <= ONE_Q && 64'(r_reg[0]) >= -ONE_Q))
        else $error("rotation entry out of range");

    a_cordic_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORDIC) |-> (cnt_reg < 7'(CORDIC_STEPS)))
        else $error("cordic step count overrun");
`endif

endmodule

/* sim/incremental_rotation_triad_update_tb.sv */
`timescale 1ns / 1ps

module incremental_rotation_triad_update_tb;
    import irtu_pkg::*;

    localparam int  N_RANDOM    = 1780;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN       = 300;

    typedef logic signed [31:0] elem_t;

    // one row of the directed table
    typedef struct {
        op_t          op;
        logic [231:0] data;
        bit           known;
        logic [287:0] triad;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [231:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [287:0] m_tdata;

    // predictor state
    elem_t committed_q [9];
    elem_t trial_q [9];

    logic [287:0] pending_triads [$];
    bit           mismatch;
    bit           quiet;
    int unsigned  cycles;

    longint atan_tab [28] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7
    };

    incremental_rotation_triad_update i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic longint rnd_shift(longint v, int n);
        longint t;
        t = v + (longint'(1) <<< (n - 1));
        return t >>> n;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // half angle sine and cosine, q.30
    function automatic void half_sincos(longint ang, output longint sn, output longint cs);
        longint x, y, z, dx, dy;
        bit     flip;
        flip = 0;
        x = 652032874;
        y = 0;
        z = ang;
        if (z > 64'sd3373259426) z -= 64'sd6746518852;
        if (z > 64'sd1686629713) begin
            z = 64'sd3373259426 - z;
            flip = 1;
        end else if (z < -64'sd1686629713) begin
            z = -64'sd3373259426 - z;
            flip = 1;
        end
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        sn = y;
        cs = flip ? -x : x;
    endfunction

    // trial = rodrigues(mean spin) * committed
    function automatic void rotate_trial(logic [231:0] d);
        longint          p [3], w [3], a [3], r [9];
        longint          s, c, h, wsq, ang, acc, one;
        longint unsigned ss, m;
        one = 64'sd1 <<< 30;
        ss = 0;
        for (int k = 0; k < 3; k++) begin
            p[k] = (longint'(elem_t'(d[32*k +: 32])) + longint'(elem_t'(d[32*(k+3) +: 32])))
                   >>> 1;
            m = p[k] < 0 ? longint'(-p[k]) : p[k];
            ss += m * m;
        end
        if (ss == 0) begin
            trial_q = committed_q;
            return;
        end
        ang = 2 * longint'(int_sqrt(ss));
        half_sincos(ang, s, c);
        h = clip((s * one) / ang, -one, one);
        c = clip(c, -one, one);
        for (int k = 0; k < 3; k++) begin
            w[k] = clip(rnd_shift(h * p[k], 30), -one, one);
            a[k] = rnd_shift(w[k] * c, 28);
        end
        wsq = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r[i*3+j] = rnd_shift(w[i] * w[j] - (i == j ? wsq : 0), 27)
                           + (i == j ? one : 0);
        r[1] -= a[2]; r[2] += a[1];
        r[3] += a[2]; r[5] -= a[0];
        r[6] -= a[1]; r[7] += a[0];
        for (int k = 0; k < 9; k++) r[k] = clip(r[k], -one, one);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += r[i*3+k] * longint'(committed_q[k*3+j]);
                trial_q[i*3+j] = elem_t'(clip(rnd_shift(acc, 30),
                                              -64'sd2147483648, 64'sd2147483647));
            end
    endfunction

    // apply one beat to the predictor and return the trial triad after it
    function automatic logic [287:0] triad_after(op_t op, logic [231:0] d);
        logic [287:0] t;
        logic [3:0]   idx;
        case (op)
            OP_UPDATE:  rotate_trial(d);
            OP_COMMIT:  committed_q = trial_q;
            OP_RESTART: trial_q = committed_q;
            default: begin
                idx = d[195:192];
                if (idx < 9) begin
                    committed_q[idx] = d[227:196];
                    trial_q[idx] = d[227:196];
                end
            end
        endcase
        for (int k = 0; k < 9; k++) t[32*k +: 32] = trial_q[k];
        return t;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [231:0] pack_beat(elem_t ax, elem_t ay, elem_t az, elem_t bx,
                                               elem_t by, elem_t bz, logic [3:0] idx,
                                               elem_t val);
        return {4'd0, val, idx, bz, by, bx, az, ay, az == az ? ax : ax};
    endfunction

    function automatic row_t mk_row(op_t op, logic [231:0] d);
        row_t r;
        r.op = op;
        r.data = d;
        r.known = 0;
        r.triad = '0;
        return r;
    endfunction

    function automatic row_t mk_known(op_t op, logic [231:0] d, logic [287:0] t);
        row_t r;
        r = mk_row(op, d);
        r.known = 1;
        r.triad = t;
        return r;
    endfunction

    function automatic elem_t rand_spin(int mode);
        elem_t v;
        case (mode)
            0:       v = $urandom;
            1:       v = $urandom_range(0, 32'h0400_0000);
            default: v = $urandom_range(0, 32'h0010_0000);
        endcase
        if (mode != 0 && $urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic logic [231:0] rand_beat(op_t op);
        elem_t      s [6];
        elem_t      val;
        logic [3:0] idx;
        int         mode;
        mode = $urandom_range(0, 5);
        for (int k = 0; k < 6; k++) s[k] = rand_spin(mode % 3);
        if (mode == 3) begin
            // opposite node increments cancel to zero spin
            s[3] = -s[0]; s[4] = -s[1]; s[5] = -s[2];
        end else if (mode == 4) begin
            s = '{0, 0, 0, 0, 0, 0};
        end
        if (op == OP_LOAD) idx = $urandom_range(0, 11) < 10 ? $urandom_range(0, 8)
                                                            : $urandom_range(0, 15);
        else idx = $urandom;
        if ($urandom_range(0, 1)) val = $urandom;
        else val = $urandom_range(0, 32'h4000_0000) * ($urandom_range(0, 1) ? 1 : -1);
        return pack_beat(s[0], s[1], s[2], s[3], s[4], s[5], idx, val);
    endfunction

    function automatic op_t rand_op();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return OP_UPDATE;
        if (p < 55) return OP_COMMIT;
        if (p < 70) return OP_RESTART;
        return OP_LOAD;
    endfunction

    // drive one beat and wait for it to be taken
    task automatic send_beat(op_t op, logic [231:0] d, bit known, logic [287:0] t);
        logic [287:0] predicted;
        s_tuser  <= op;
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = triad_after(op, d);
        pending_triads.push_back(known ? t : predicted);
        if (!quiet && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin
        row_t         rows [$];
        logic [287:0] ident;
        elem_t        maxv, minv;
        op_t          op;

        maxv = 32'sh7fff_ffff;
        minv = 32'sh8000_0000;
        ident = '0;
        for (int k = 0; k < 9; k += 4) ident[32*k +: 32] = 32'sd1073741824;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_UPDATE;
        aresetn  = 1'b0;
        quiet    = 1'b0;
        mismatch = 1'b0;
        for (int k = 0; k < 9; k++) begin
            committed_q[k] = (k % 4 == 0) ? 32'sd1073741824 : 32'sd0;
            trial_q[k] = committed_q[k];
        end

        // directed table: identity answers after reset, everything else predicted
        rows.push_back(mk_known(OP_RESTART, pack_beat(maxv, minv, 1, -1, 0, 5, 4'd15, minv),
                                ident));
        rows.push_back(mk_known(OP_COMMIT, pack_beat(minv, maxv, -1, 1, 7, 0, 4'd0, maxv),
                                ident));
        rows.push_back(mk_known(OP_UPDATE, pack_beat(0, 0, 0, 0, 0, 0, 4'd0, 0), ident));
        rows.push_back(mk_known(OP_UPDATE, pack_beat(12345, -678, 90, -12345, 678, -90,
                                                     4'd3, 0), ident));
        rows.push_back(mk_known(OP_LOAD, pack_beat(0, 0, 0, 0, 0, 0, 4'd9, maxv), ident));
        rows.push_back(mk_known(OP_LOAD, pack_beat(0, 0, 0, 0, 0, 0, 4'd15, minv), ident));
        rows.push_back(mk_row(OP_UPDATE, pack_beat(26843546, 0, 0, 26843546, 0, 0, 4'd0, 0)));
        rows.push_back(mk_row(OP_UPDATE, pack_beat(0, 1, 0, 0, 0, 0, 4'd0, 0)));
        rows.push_back(mk_row(OP_COMMIT, '0));
        rows.push_back(mk_row(OP_UPDATE, pack_beat(maxv, maxv, maxv, maxv, maxv, maxv,
                                                   4'd0, 0)));
        rows.push_back(mk_row(OP_UPDATE, pack_beat(minv, minv, minv, minv, minv, minv,
                                                   4'd0, 0)));
        rows.push_back(mk_row(OP_UPDATE, pack_beat(maxv, minv, 0, maxv, minv, 0, 4'd0, 0)));
        rows.push_back(mk_row(OP_RESTART, '1));
        rows.push_back(mk_row(OP_LOAD, pack_beat(0, 0, 0, 0, 0, 0, 4'd0, maxv)));
        rows.push_back(mk_row(OP_LOAD, pack_beat(0, 0, 0, 0, 0, 0, 4'd1, maxv)));
        rows.push_back(mk_row(OP_LOAD, pack_beat(0, 0, 0, 0, 0, 0, 4'd2, maxv)));
        rows.push_back(mk_row(OP_LOAD, pack_beat(0, 0, 0, 0, 0, 0, 4'd8, minv)));
        // saturating products from an overfull committed triad
        rows.push_back(mk_row(OP_UPDATE, pack_beat(0, 0, 421657428, 0, 0, 421657428,
                                                   4'd0, 0)));
        rows.push_back(mk_row(OP_UPDATE, pack_beat(-300000000, 200000000, 100000000,
                                                   100000000, -50000000, 7, 4'd0, 0)));
        rows.push_back(mk_row(OP_COMMIT, '0));
        rows.push_back(mk_row(OP_RESTART, '0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_beat(rows[i].op, rows[i].data, rows[i].known, rows[i].triad);

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 500 && n < 800);
            if (n == 1000) begin
                // hold off until the block has nothing outstanding
                s_tvalid <= 1'b0;
                while (pending_triads.size() != 0) @(posedge aclk);
            end
            op = rand_op();
            send_beat(op, rand_beat(op), 0, '0);
        end
        quiet = 0;
        s_tvalid <= 1'b0;

        while (pending_triads.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        if (!mismatch) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ---------------------------------------------------------------- result side

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge aclk) begin
        logic [287:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_triads.size() == 0) begin
                $error("output beat with no expected triad");
                mismatch <= 1'b1;
            end else begin
                want = pending_triads.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (m_tdata[32*k +: 32] !== want[32*k +: 32]) begin
                        $error("trial_r%0d%0d expected %0d got %0d", k / 3 + 1, k % 3 + 1,
                               elem_t'(want[32*k +: 32]), elem_t'(m_tdata[32*k +: 32]));
                        mismatch <= 1'b1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial cycles = 0;

endmodule

/* filelist.f */
hdl/irtu_pkg.sv
hdl/incremental_rotation_triad_update.sv
sim/incremental_rotation_triad_update_tb.sv
